// ===== src/pmsu_pkg.sv =====
// ----------------------------------------------------------------------------
// pmsu_pkg
// Types, codes and saturation helper shared by the particle step unit.
// ----------------------------------------------------------------------------
package pmsu_pkg;

   localparam int WordW     = 32;
   localparam int SatInW    = 34;
   localparam int ProdW     = 50;
   localparam int FactW     = 17;
   localparam int WinW      = 15;
   localparam int AttrW     = 16;
   localparam int CfgFrac   = 16;
   localparam int CsrIdxW   = 2;
   localparam int CsrDataW  = 17;
   localparam int NumStages = 4;

   typedef enum logic {
      OP_UPDATE  = 1'b0,
      OP_COLLIDE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      NUDGE_X_DEC = 2'd0,
      NUDGE_Y_INC = 2'd1,
      NUDGE_X_INC = 2'd2,
      NUDGE_Y_DEC = 2'd3
   } nudge_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_WINDOW  = 2'd0,
      CSR_DRAG    = 2'd1,
      CSR_BOUNCE  = 2'd2,
      CSR_GRAVITY = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [WinW-1:0]  wall_units;
      logic [FactW-1:0] drag_keep_q16;
      logic [FactW-1:0] bounce_q16;
      logic [FactW-1:0] gravity_q16;
   } cfg_type;

   localparam cfg_type CfgReset = '{
      wall_units:    15'd400,
      drag_keep_q16: 17'd65470,
      bounce_q16:    17'd13107,
      gravity_q16:   17'd328
   };

   typedef struct packed {
      op_type                    op;
      logic signed [WordW-1:0]   pos_x;
      logic signed [WordW-1:0]   pos_y;
      logic signed [WordW-1:0]   mom_x;
      logic signed [WordW-1:0]   mom_y;
      logic signed [AttrW-1:0]   attract_x;
      logic signed [AttrW-1:0]   attract_y;
      logic signed [WordW-1:0]   other_mom_x;
      logic signed [WordW-1:0]   other_mom_y;
      nudge_type                 nudge_dir;
   } req_word_type;

   typedef struct packed {
      logic signed [WordW-1:0] new_pos_x;
      logic signed [WordW-1:0] new_pos_y;
      logic signed [WordW-1:0] new_mom_x;
      logic signed [WordW-1:0] new_mom_y;
   } rsp_word_type;

   // clamp to the signed 32-bit range
   function automatic logic signed [WordW-1:0] sat_word(input logic signed [SatInW-1:0] v);
      logic signed [WordW-1:0] res;
      if ((v[SatInW-1:WordW-1] == '0) || (v[SatInW-1:WordW-1] == '1)) begin
         res = v[WordW-1:0];
      end else if (v[SatInW-1]) begin
         res = {1'b1, {(WordW-1){1'b0}}};
      end else begin
         res = {1'b0, {(WordW-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

// ===== src/pmsu_if.sv =====
// ----------------------------------------------------------------------------
// pmsu_if
// Valid/ready channels carrying request and response words.
// ----------------------------------------------------------------------------
interface pmsu_req_if;
   import pmsu_pkg::*;

   logic         valid;
   logic         ready;
   req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface pmsu_rsp_if;
   import pmsu_pkg::*;

   logic         valid;
   logic         ready;
   rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

// ===== src/pmsu_collide.sv =====
// ----------------------------------------------------------------------------
// pmsu_collide
// Collide position nudge: one unit along the axis the direction code selects.
// ----------------------------------------------------------------------------
module pmsu_collide #(
   parameter int FRAC_BITS = 16
) (
   input  logic signed [pmsu_pkg::WordW-1:0] pos_x,
   input  logic signed [pmsu_pkg::WordW-1:0] pos_y,
   input  pmsu_pkg::nudge_type               nudge_dir,
   output logic signed [pmsu_pkg::WordW-1:0] npos_x,
   output logic signed [pmsu_pkg::WordW-1:0] npos_y
);
   import pmsu_pkg::*;

   localparam logic signed [SatInW-1:0] Unit = SatInW'(1) << FRAC_BITS;

   logic signed [SatInW-1:0] px_ext;
   logic signed [SatInW-1:0] py_ext;

   assign px_ext = SatInW'(pos_x);
   assign py_ext = SatInW'(pos_y);

   always_comb begin
      npos_x = pos_x;
      npos_y = pos_y;
      unique case (nudge_dir)
         NUDGE_X_DEC: npos_x = sat_word(px_ext - Unit);
         NUDGE_Y_INC: npos_y = sat_word(py_ext + Unit);
         NUDGE_X_INC: npos_x = sat_word(px_ext + Unit);
         NUDGE_Y_DEC: npos_y = sat_word(py_ext - Unit);
         default: begin
            npos_x = pos_x;
            npos_y = pos_y;
         end
      endcase
   end

endmodule

// ===== src/pmsu_axis.sv =====
// ----------------------------------------------------------------------------
// pmsu_axis
// Four-stage update pipeline for one axis: move and drag, wall clamp,
// bounce product, bounce select and gravity pull.
// ----------------------------------------------------------------------------
module pmsu_axis #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic [pmsu_pkg::NumStages-1:0]      adv,
   input  pmsu_pkg::cfg_type                   cfg,
   input  logic signed [pmsu_pkg::WordW-1:0]   pos,
   input  logic signed [pmsu_pkg::WordW-1:0]   mom,
   input  logic signed [pmsu_pkg::AttrW-1:0]   attract,
   output logic signed [pmsu_pkg::WordW-1:0]   pos_out,
   output logic signed [pmsu_pkg::WordW-1:0]   mom_out
);
   import pmsu_pkg::*;

   localparam int WallW = WinW + FRAC_BITS;
   localparam int TgtW  = AttrW + FRAC_BITS;
   localparam int CmpW  = (TgtW > WordW) ? TgtW : WordW;
   localparam int GravW = (FRAC_BITS >= CfgFrac) ? FactW + FRAC_BITS - CfgFrac : FactW;

   // wall, gravity and factor operands from configuration
   logic [WallW-1:0]          wall_raw;
   logic [WordW-2:0]          wall_mag;
   logic signed [WordW-1:0]   wall_s;
   logic [GravW-1:0]          grav;
   logic signed [FactW:0]     drag_s;
   logic signed [FactW:0]     bneg_s;

   assign wall_raw = {cfg.wall_units, FRAC_BITS'(0)};

   generate
      if (WallW > WordW - 1) begin : g_wall_sat
         assign wall_mag = (|wall_raw[WallW-1:WordW-1]) ? '1 : wall_raw[WordW-2:0];
      end else begin : g_wall_fit
         assign wall_mag = (WordW-1)'(wall_raw);
      end
      if (FRAC_BITS >= CfgFrac) begin : g_grav_up
         assign grav = GravW'(cfg.gravity_q16) << (FRAC_BITS - CfgFrac);
      end else begin : g_grav_down
         assign grav = GravW'(cfg.gravity_q16 >> (CfgFrac - FRAC_BITS));
      end
   endgenerate

   assign wall_s = signed'({1'b0, wall_mag});
   assign drag_s = signed'({1'b0, cfg.drag_keep_q16});
   assign bneg_s = (FactW+1)'(0) - signed'({1'b0, cfg.bounce_q16});

   // stage 1: move, drag product
   logic signed [WordW-1:0] p1_in, p1_ff;
   logic signed [ProdW-1:0] prod1_in, prod1_ff;
   logic signed [AttrW-1:0] attr1_ff;

   assign p1_in    = sat_word(SatInW'(pos) + SatInW'(mom));
   assign prod1_in = mom * drag_s;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         p1_ff    <= p1_in;
         prod1_ff <= prod1_in;
         attr1_ff <= attract;
      end
   end

   // stage 2: drag scale, wall clamp
   logic signed [WordW-1:0] m2_in, m2_ff;
   logic signed [WordW-1:0] p2_in, p2_ff;
   logic                    hit2_in, hit2_ff;
   logic signed [AttrW-1:0] attr2_ff;
   logic                    below0, above_wall;

   assign m2_in      = sat_word(signed'(prod1_ff[ProdW-1:CfgFrac]));
   assign below0     = p1_ff[WordW-1];
   assign above_wall = p1_ff > wall_s;
   assign hit2_in    = below0 || above_wall;
   assign p2_in      = below0 ? '0 : (above_wall ? wall_s : p1_ff);

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         m2_ff    <= m2_in;
         p2_ff    <= p2_in;
         hit2_ff  <= hit2_in;
         attr2_ff <= attr1_ff;
      end
   end

   // stage 3: negated bounce product
   logic signed [ProdW-1:0] bprod3_in, bprod3_ff;
   logic signed [WordW-1:0] m3_ff, p3_ff;
   logic                    hit3_ff;
   logic signed [AttrW-1:0] attr3_ff;

   assign bprod3_in = m2_ff * bneg_s;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         bprod3_ff <= bprod3_in;
         m3_ff     <= m2_ff;
         p3_ff     <= p2_ff;
         hit3_ff   <= hit2_ff;
         attr3_ff  <= attr2_ff;
      end
   end

   // stage 4: bounce select, gravity toward attractor
   logic signed [WordW-1:0]  mb;
   logic signed [CmpW-1:0]   pw, tgt;
   logic signed [SatInW-1:0] mb_ext, g_ext;
   logic signed [WordW-1:0]  mom4_in;
   logic signed [WordW-1:0]  pos_out_ff, mom_out_ff;

   assign mb     = hit3_ff ? sat_word(signed'(bprod3_ff[ProdW-1:CfgFrac])) : m3_ff;
   assign pw     = CmpW'(p3_ff);
   assign tgt    = CmpW'(signed'({attr3_ff, FRAC_BITS'(0)}));
   assign mb_ext = SatInW'(mb);
   assign g_ext  = signed'(SatInW'(grav));

   always_comb begin
      priority if (pw < tgt) begin
         mom4_in = sat_word(mb_ext + g_ext);
      end else if (pw > tgt) begin
         mom4_in = sat_word(mb_ext - g_ext);
      end else begin
         mom4_in = mb;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         pos_out_ff <= p3_ff;
         mom_out_ff <= mom4_in;
      end
   end

   assign pos_out = pos_out_ff;
   assign mom_out = mom_out_ff;

endmodule

// ===== src/particle_motion_step_unit.sv =====
// ----------------------------------------------------------------------------
// particle_motion_step_unit
// Stateless 2-D particle step in signed fixed point, update or collide.
// ----------------------------------------------------------------------------
// Takes one request word per clock while the response side keeps up, and
// returns exactly one response word for each, in order.
// The four register stages are set by the update path: add and drag product,
// drag scale and wall clamp, bounce product, then bounce select and gravity.
// A stalled response fills empty stages first, so the input keeps accepting
// words until every stage holds one. Write configuration only while idle.
module particle_motion_step_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   pmsu_req_if.sink                          req_bus,
   pmsu_rsp_if.source                        rsp_bus,
   input  logic                              csr_wr_en,
   input  logic [pmsu_pkg::CsrIdxW-1:0]      csr_index,
   input  logic [pmsu_pkg::CsrDataW-1:0]     csr_wdata
);
   import pmsu_pkg::*;

   localparam int Last = NumStages - 1;

   // configuration registers
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CfgReset;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_WINDOW:  cfg_ff.wall_units    <= csr_wdata[WinW-1:0];
            CSR_DRAG:    cfg_ff.drag_keep_q16 <= csr_wdata[FactW-1:0];
            CSR_BOUNCE:  cfg_ff.bounce_q16    <= csr_wdata[FactW-1:0];
            CSR_GRAVITY: cfg_ff.gravity_q16   <= csr_wdata[FactW-1:0];
            default:     cfg_ff <= cfg_ff;
         endcase
      end
   end

   // stage control: a stage advances when empty or when the next one advances
   logic [NumStages-1:0] vld_ff;
   logic [NumStages-1:0] adv;

   always_comb begin
      adv[Last] = !vld_ff[Last] || rsp_bus.ready;
      for (int i = Last - 1; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   assign req_bus.ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_bus.valid;
         end
         for (int i = 1; i < NumStages; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // collide path: computed at entry, carried alongside the update stages
   logic signed [WordW-1:0] npos_x, npos_y;
   rsp_word_type            coll_in;
   rsp_word_type            coll_ff [NumStages];
   op_type                  op_ff   [NumStages];

   pmsu_collide #(
      .FRAC_BITS (FRAC_BITS)
   ) u_collide (
      .pos_x     (req_bus.word.pos_x),
      .pos_y     (req_bus.word.pos_y),
      .nudge_dir (req_bus.word.nudge_dir),
      .npos_x    (npos_x),
      .npos_y    (npos_y)
   );

   assign coll_in = '{
      new_pos_x: npos_x,
      new_pos_y: npos_y,
      new_mom_x: req_bus.word.other_mom_y,
      new_mom_y: req_bus.word.other_mom_x
   };

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         coll_ff[0] <= coll_in;
         op_ff[0]   <= req_bus.word.op;
      end
      for (int i = 1; i < NumStages; i++) begin
         if (adv[i]) begin
            coll_ff[i] <= coll_ff[i-1];
            op_ff[i]   <= op_ff[i-1];
         end
      end
   end

   // update path, one pipeline per axis
   logic signed [WordW-1:0] upd_pos_x, upd_mom_x, upd_pos_y, upd_mom_y;

   pmsu_axis #(
      .FRAC_BITS (FRAC_BITS)
   ) u_axis_x (
      .clock   (clock),
      .adv     (adv),
      .cfg     (cfg_ff),
      .pos     (req_bus.word.pos_x),
      .mom     (req_bus.word.mom_x),
      .attract (req_bus.word.attract_x),
      .pos_out (upd_pos_x),
      .mom_out (upd_mom_x)
   );

   pmsu_axis #(
      .FRAC_BITS (FRAC_BITS)
   ) u_axis_y (
      .clock   (clock),
      .adv     (adv),
      .cfg     (cfg_ff),
      .pos     (req_bus.word.pos_y),
      .mom     (req_bus.word.mom_y),
      .attract (req_bus.word.attract_y),
      .pos_out (upd_pos_y),
      .mom_out (upd_mom_y)
   );

   // response select
   rsp_word_type upd_word;

   assign upd_word = '{
      new_pos_x: upd_pos_x,
      new_pos_y: upd_pos_y,
      new_mom_x: upd_mom_x,
      new_mom_y: upd_mom_y
   };

   assign rsp_bus.valid = vld_ff[Last];
   assign rsp_bus.word  = (op_ff[Last] == OP_COLLIDE) ? coll_ff[Last] : upd_word;

   // checks
   a_full_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      ((&vld_ff) && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("input accepted while every stage is full and stalled");

   a_accept_fills_entry: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> vld_ff[0])
      else $error("accepted word missing from the entry stage");

   a_update_in_window: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (op_ff[Last] == OP_UPDATE))
         |-> (!rsp_bus.word.new_pos_x[WordW-1] && !rsp_bus.word.new_pos_y[WordW-1]))
      else $error("update position below the lower wall");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("response valid right after reset");

endmodule
